// File: rtl/ebdc_pkg.sv
`timescale 1ns / 1ps
package ebdc_pkg;

  localparam int HEADER_WORDS_DEF  = 16;
  localparam int FAMILY_COUNT_DEF  = 128;
  localparam int POSITION_BITS_DEF = 16;
  localparam int FAM_BITS          = 7;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_BITS         = 2;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE, PH_TAG, PH_HEADER, PH_HUNT, PH_LENGTH,
    PH_SKIP, PH_REC, PH_RECLEN, PH_DRAIN, PH_DEAD
  } phase_t;

  typedef struct packed {
    logic [15:0] word;
    logic        first_word;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        new_family;
    logic [6:0]  family;
    logic [1:0]  format;
    logic [4:0]  code;
    logic [8:0]  id;
    logic [14:0] record_words;
    logic [8:0]  max_id;
    logic [14:0] max_words;
    logic [15:0] event_count;
  } out_item_t;

  // front -> back command
  typedef struct packed {
    logic        census;   // table update wanted
    logic        emit;     // result leaves (record or end)
    logic [1:0]  kind;
    logic [15:0] rec;
    logic [14:0] len;
    logic [15:0] event_count;
  } cmd_t;

  function automatic logic [15:0] tag_word(input logic [1:0] i);
    case (i)
      2'd0: tag_word = 16'h4245;
      2'd1: tag_word = 16'h5645;
      2'd2: tag_word = 16'h4E45;
      default: tag_word = 16'h4454;
    endcase
  endfunction

  function automatic logic [2:0] skip_words(input logic [1:0] t);
    case (t)
      2'd0: skip_words = 3'd2;
      2'd1: skip_words = 3'd4;
      2'd2: skip_words = 3'd3;
      default: skip_words = 3'd5;
    endcase
  endfunction

endpackage

// File: rtl/ebdc_front.sv
`timescale 1ns / 1ps
module ebdc_front #(
  parameter int HEADER_WORDS  = ebdc_pkg::HEADER_WORDS_DEF,
  parameter int POSITION_BITS = ebdc_pkg::POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  ebdc_pkg::in_item_t item,
  output logic              cmd_push,
  output ebdc_pkg::cmd_t    cmd
);
  // sums are wide enough for a full position plus a 15-bit length
  localparam int SW = ((POSITION_BITS > 15) ? POSITION_BITS : 15) + 1;
  localparam logic [SW-1:0] PMAX = (SW'(1) << POSITION_BITS) - SW'(1);
  localparam logic [POSITION_BITS-1:0] P3 = POSITION_BITS'(3);

  ebdc_pkg::phase_t ph_r, ph_nxt, ph_eff;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, ev_end_r, ev_end_nxt, rec_end_r, rec_end_nxt;
  logic [1:0]  ekind_r, ekind_nxt;
  logic [15:0] pend_r, pend_nxt, evs_r, evs_nxt;
  logic [POSITION_BITS-1:0] pos;
  logic [SW-1:0] s_ev, s_rec, s_pos;
  logic rejected, census, active;
  logic [15:0] w, crec;
  logic [14:0] clen, half;

  function automatic logic [POSITION_BITS-1:0] sat(input logic [SW-1:0] s);
    sat = (s > PMAX) ? PMAX[POSITION_BITS-1:0] : s[POSITION_BITS-1:0];
  endfunction

  assign w    = item.word;
  assign half = w[15:1];

  always_comb begin
    ph_nxt = ph_r; pos_nxt = pos_r; ev_end_nxt = ev_end_r; rec_end_nxt = rec_end_r;
    ekind_nxt = ekind_r; pend_nxt = pend_r; evs_nxt = evs_r;
    rejected = 1'b0; census = 1'b0; crec = w; clen = '0; active = 1'b1;
    pos = pos_r; ph_eff = ph_r; s_ev = '0; s_rec = '0; s_pos = '0;
    if (item.first_word) begin
      ph_eff = ebdc_pkg::PH_TAG; pos = '0; evs_nxt = '0;
      ev_end_nxt = '0; rec_end_nxt = '0; ekind_nxt = '0; pend_nxt = '0;
    end else if (ph_r == ebdc_pkg::PH_IDLE) begin
      active = 1'b0;
    end else if (ph_r == ebdc_pkg::PH_DEAD) begin
      active = 1'b0;
      if (item.last_word) ph_nxt = ebdc_pkg::PH_IDLE;
    end
    if (active) begin
      if (ph_eff == ebdc_pkg::PH_HEADER && SW'(pos) >= SW'(HEADER_WORDS))
        ph_eff = ebdc_pkg::PH_HUNT;
      if (ph_eff == ebdc_pkg::PH_SKIP && pos >= rec_end_nxt)
        ph_eff = ({1'b0, pos} + 1'b1 < {1'b0, ev_end_nxt}) ? ebdc_pkg::PH_REC
                                                           : ebdc_pkg::PH_DRAIN;
      if (ph_eff == ebdc_pkg::PH_DRAIN && pos >= ev_end_nxt) ph_eff = ebdc_pkg::PH_HUNT;
      ph_nxt = ph_eff;
      case (ph_eff)
        ebdc_pkg::PH_TAG: begin
          if (pos > P3 || w != ebdc_pkg::tag_word(pos[1:0])) rejected = 1'b1;
          else if (pos == P3) ph_nxt = ebdc_pkg::PH_HEADER;
        end
        ebdc_pkg::PH_HUNT: begin
          if (w[15:4] == 12'hFFF) begin
            if (w[3:0] > 4'd3) rejected = 1'b1;
            else begin ekind_nxt = w[1:0]; ph_nxt = ebdc_pkg::PH_LENGTH; end
          end
        end
        ebdc_pkg::PH_LENGTH: begin
          if (half == '0) ph_nxt = ebdc_pkg::PH_HUNT;
          else begin
            if (evs_nxt != 16'hFFFF) evs_nxt = evs_nxt + 16'd1;
            s_ev  = SW'(pos - 1'b1) + SW'(half);
            s_rec = SW'(pos - 1'b1) + SW'(ebdc_pkg::skip_words(ekind_nxt));
            ev_end_nxt = sat(s_ev); rec_end_nxt = sat(s_rec);
            ph_nxt = ebdc_pkg::PH_SKIP;
          end
        end
        ebdc_pkg::PH_REC: begin
          if (w[15:14] == 2'd0) begin
            census = 1'b1; ph_nxt = ebdc_pkg::PH_DRAIN;
          end else begin
            pend_nxt = w; ph_nxt = ebdc_pkg::PH_RECLEN;
          end
        end
        ebdc_pkg::PH_RECLEN: begin
          census = 1'b1; crec = pend_r; clen = half;
          if (half < 15'd2) ph_nxt = ebdc_pkg::PH_DRAIN;
          else begin
            s_rec = SW'(pos - 1'b1) + SW'(half);
            rec_end_nxt = sat(s_rec); ph_nxt = ebdc_pkg::PH_SKIP;
          end
        end
        default: ;
      endcase
      s_pos = SW'(pos) + SW'(1);
      pos_nxt = sat(s_pos);
      if (rejected) ph_nxt = item.last_word ? ebdc_pkg::PH_IDLE : ebdc_pkg::PH_DEAD;
      else if (item.last_word) ph_nxt = ebdc_pkg::PH_IDLE;
    end
  end

  always_comb begin
    cmd.census = census;
    cmd.rec = crec;
    cmd.len = clen;
    cmd.event_count = evs_nxt;
    cmd.emit = census;
    cmd.kind = ebdc_pkg::KIND_RECORD;
    // tag still incomplete after this word: a matching fourth word completes it
    if (rejected || (active && item.last_word && ph_eff == ebdc_pkg::PH_TAG &&
                     pos != P3)) begin
      cmd.emit = 1'b1; cmd.kind = ebdc_pkg::KIND_REJECT;
    end else if (active && item.last_word) begin
      cmd.emit = 1'b1; cmd.kind = ebdc_pkg::KIND_DONE;
    end
  end
  // a rejected block that also ends here is handled by the rejected arm above
  assign cmd_push = take && active && (cmd.emit || census);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= ebdc_pkg::PH_IDLE; pos_r <= '0; ev_end_r <= '0; rec_end_r <= '0;
      ekind_r <= '0; pend_r <= '0; evs_r <= '0;
    end else if (take) begin
      ph_r <= ph_nxt; pos_r <= pos_nxt; ev_end_r <= ev_end_nxt; rec_end_r <= rec_end_nxt;
      ekind_r <= ekind_nxt; pend_r <= pend_nxt; evs_r <= evs_nxt;
    end
  end
endmodule

// File: rtl/ebdc_queue.sv
`timescale 1ns / 1ps
module ebdc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ebdc_pkg::cmd_t push_data,
  input  logic           pop,
  output logic           not_empty,
  output logic           room,
  output ebdc_pkg::cmd_t head
);
  ebdc_pkg::cmd_t mem_r [ebdc_pkg::QUEUE_DEPTH];
  logic [ebdc_pkg::QPTR_BITS-1:0] wp_r, rp_r;
  logic [ebdc_pkg::QPTR_BITS:0]   cnt_r;

  assign not_empty = cnt_r != '0;
  // keep one slot spare: room drops once three entries are held, and the front pushes only while room is high
  assign room = cnt_r < (ebdc_pkg::QPTR_BITS+1)'(ebdc_pkg::QUEUE_DEPTH - 1);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (ebdc_pkg::QPTR_BITS+1)'(push) - (ebdc_pkg::QPTR_BITS+1)'(pop);
    end
  end
endmodule

// File: rtl/ebdc_back.sv
`timescale 1ns / 1ps
module ebdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_r[rd_addr];
  end
endmodule

module ebdc_back #(
  parameter int FAMILY_COUNT = ebdc_pkg::FAMILY_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ebdc_pkg::cmd_t     q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ebdc_pkg::out_item_t out_item
);
  localparam int FB = $clog2(FAMILY_COUNT);
  localparam int EW = 24;

  // table entry in RAM: max id, max words; valid bits in flops, cleared at reset
  logic [FAMILY_COUNT-1:0] vld_r;
  ebdc_pkg::cmd_t st_r;
  logic           st_valid_r;
  // last written entry, forwarded over a read that raced the write
  logic [FB-1:0]  lw_fam_r;
  logic [EW-1:0]  lw_data_r;

  logic [FB-1:0] rd_fam, fam;
  logic [EW-1:0] rd_data, ent, wr_data;
  logic [8:0]  id, old_mid, new_mid;
  logic [14:0] old_mw, new_mw;
  logic        created, out_free, st_done, wr_en;
  ebdc_pkg::out_item_t res;

  assign out_free = !out_valid || !out_stall;
  assign st_done  = st_valid_r && out_free;
  assign q_pop    = q_valid && (!st_valid_r || st_done);
  assign rd_fam   = q_head.rec[9 +: FB];
  assign fam      = st_r.rec[9 +: FB];
  assign id       = st_r.rec[8:0];
  assign ent      = (lw_fam_r == fam) ? lw_data_r : rd_data;
  assign old_mid  = ent[23:15];
  assign old_mw   = ent[14:0];
  assign created  = !vld_r[fam];
  assign new_mid  = (created || old_mid < id) ? id : old_mid;
  assign new_mw   = (created || old_mw < st_r.len) ? st_r.len : old_mw;
  assign wr_en    = st_done && st_r.census;
  assign wr_data  = {new_mid, new_mw};

  ebdc_ram #(.WIDTH(EW), .DEPTH(FAMILY_COUNT)) u_table (
    .clk, .rd_en(q_pop), .rd_addr(rd_fam), .rd_data,
    .wr_en, .wr_addr(fam), .wr_data
  );

  always_comb begin
    res = '0;
    res.kind = st_r.kind;
    res.event_count = st_r.event_count;
    if (st_r.kind == ebdc_pkg::KIND_RECORD) begin
      res.new_family = created;
      res.family = st_r.rec[15:9];
      res.format = st_r.rec[15:14];
      res.code = st_r.rec[13:9];
      res.id = id;
      res.record_words = st_r.len;
      res.max_id = new_mid;
      res.max_words = new_mw;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) st_r <= q_head;
    if (wr_en) begin
      lw_fam_r <= fam; lw_data_r <= wr_data;
    end
    if (st_done && st_r.emit) out_item <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0; st_valid_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (wr_en) vld_r[fam] <= 1'b1;
      if (q_pop) st_valid_r <= 1'b1;
      else if (st_done) st_valid_r <= 1'b0;
      if (out_free) out_valid <= st_done && st_r.emit;
    end
  end
endmodule

// File: rtl/event_block_detector_census.sv
`timescale 1ns / 1ps
// A word's result passes from the front through the command queue, the table read stage
// and the output register before it is presented.
// Throughput: one word per cycle; the front stops taking words only when the
// 4-entry command queue is nearly full because the result side is stalled.
// Reset (rst_n low, synchronous): phase idle, counters and queue empty, all
// family table entries invalid; no clearing pass is needed.
module event_block_detector_census #(
  parameter int HEADER_WORDS  = ebdc_pkg::HEADER_WORDS_DEF,
  parameter int FAMILY_COUNT  = ebdc_pkg::FAMILY_COUNT_DEF,
  parameter int POSITION_BITS = ebdc_pkg::POSITION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ebdc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ebdc_pkg::out_item_t out_data
);
  logic take, push, q_valid, q_room, q_pop;
  ebdc_pkg::cmd_t cmd, head;

  // front stalls only on queue space; every word may push one command
  assign in_stall = !q_room;
  assign take     = in_valid && q_room;

  ebdc_front #(.HEADER_WORDS(HEADER_WORDS), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk, .rst_n, .take, .item(in_data), .cmd_push(push), .cmd
  );

  ebdc_queue u_queue (
    .clk, .rst_n, .push, .push_data(cmd), .pop(q_pop),
    .not_empty(q_valid), .room(q_room), .head
  );

  ebdc_back #(.FAMILY_COUNT(FAMILY_COUNT)) u_back (
    .clk, .rst_n, .q_valid, .q_head(head), .q_pop,
    .out_valid, .out_stall, .out_item(out_data)
  );
endmodule

// File: rtl/ebdc_checker.sv
`timescale 1ns / 1ps
module ebdc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ebdc_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("out held");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind != 2'd3) else $error("bad kind");
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != ebdc_pkg::KIND_RECORD |->
      out_data.id == '0 && out_data.max_id == '0) else $error("end fields");
  a_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == ebdc_pkg::KIND_RECORD |->
      out_data.max_id >= out_data.id && out_data.max_words >= out_data.record_words)
    else $error("max");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("reset");
endmodule

bind event_block_detector_census ebdc_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_data
);
